### rtl/core/c8alu_pkg.sv
`timescale 1ns / 1ps

package c8alu_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned OpWidth   = 4;

  typedef enum logic [OpWidth-1:0] {
    OP_ADC  = 4'd0,
    OP_SBC  = 4'd1,
    OP_AND  = 4'd2,
    OP_OR   = 4'd3,
    OP_XOR  = 4'd4,
    OP_CMP  = 4'd5,
    OP_BIT  = 4'd6,
    OP_ASL  = 4'd7,
    OP_LSR  = 4'd8,
    OP_ROL  = 4'd9,
    OP_ROR  = 4'd10,
    OP_INC  = 4'd11,
    OP_DEC  = 4'd12,
    OP_LOAD = 4'd13
  } op_e;

  typedef struct packed {
    logic [OpWidth-1:0]   req_type;
    logic [DataWidth-1:0] acc_in;
    logic [DataWidth-1:0] operand;
    logic                 carry_in;
    logic                 overflow_in;
  } req_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 carry_out;
    logic                 zero_out;
    logic                 negative_out;
    logic                 overflow_out;
  } rsp_t;

endpackage

### rtl/core/c8alu_req_if.sv
`timescale 1ns / 1ps

interface c8alu_req_if;
  logic                              valid;
  logic                              ready;
  logic [c8alu_pkg::OpWidth-1:0]     req_type;
  logic [c8alu_pkg::DataWidth-1:0]   acc_in;
  logic [c8alu_pkg::DataWidth-1:0]   operand;
  logic                              carry_in;
  logic                              overflow_in;

  modport source (
    output valid, req_type, acc_in, operand, carry_in, overflow_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, acc_in, operand, carry_in, overflow_in,
    output ready
  );
endinterface

### rtl/core/c8alu_rsp_if.sv
`timescale 1ns / 1ps

interface c8alu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [c8alu_pkg::DataWidth-1:0]   result;
  logic                              carry_out;
  logic                              zero_out;
  logic                              negative_out;
  logic                              overflow_out;

  modport source (
    output valid, result, carry_out, zero_out, negative_out, overflow_out,
    input  ready
  );

  modport sink (
    input  valid, result, carry_out, zero_out, negative_out, overflow_out,
    output ready
  );
endinterface

### rtl/core/c8alu_core.sv
`timescale 1ns / 1ps

module c8alu_core (
  input  c8alu_pkg::req_t req_i,
  output c8alu_pkg::rsp_t rsp_o
);

  localparam int unsigned W = c8alu_pkg::DataWidth;

  c8alu_pkg::op_e op;
  logic [W-1:0]   a;
  logic [W-1:0]   m;
  logic [W-1:0]   addend;
  logic [W:0]     sum;
  logic [W:0]     diff;
  logic [W-1:0]   r;
  logic           c;
  logic           v;
  logic           z;
  logic           n;

  assign op = c8alu_pkg::op_e'(req_i.req_type);
  assign a  = req_i.acc_in;
  assign m  = req_i.operand;

  // SBC is ADC on the inverted operand; carry set means no borrow
  assign addend = (op == c8alu_pkg::OP_SBC) ? ~m : m;
  assign sum    = {1'b0, a} + {1'b0, addend} + {{W{1'b0}}, req_i.carry_in};
  assign diff   = {1'b0, a} - {1'b0, m};

  always_comb begin
    r = a;
    c = req_i.carry_in;
    v = req_i.overflow_in;
    z = (r == '0);
    n = r[W-1];
    unique case (op) inside
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        r = sum[W-1:0];
        c = sum[W];
        v = ~(a[W-1] ^ addend[W-1]) & (a[W-1] ^ sum[W-1]);
      end
      c8alu_pkg::OP_AND:  r = a & m;
      c8alu_pkg::OP_OR:   r = a | m;
      c8alu_pkg::OP_XOR:  r = a ^ m;
      c8alu_pkg::OP_CMP:  r = a;
      c8alu_pkg::OP_BIT:  r = a;
      c8alu_pkg::OP_ASL: begin
        r = {m[W-2:0], 1'b0};
        c = m[W-1];
      end
      c8alu_pkg::OP_LSR: begin
        r = {1'b0, m[W-1:1]};
        c = m[0];
      end
      c8alu_pkg::OP_ROL: begin
        r = {m[W-2:0], req_i.carry_in};
        c = m[W-1];
      end
      c8alu_pkg::OP_ROR: begin
        r = {req_i.carry_in, m[W-1:1]};
        c = m[0];
      end
      c8alu_pkg::OP_INC:  r = m + W'(1);
      c8alu_pkg::OP_DEC:  r = m - W'(1);
      c8alu_pkg::OP_LOAD: r = m;
      default:            r = a;
    endcase

    z = (r == '0);
    n = r[W-1];

    // compare and bit test take their flags from elsewhere
    if (op == c8alu_pkg::OP_CMP) begin
      c = ~diff[W];
      z = (a == m);
      n = diff[W-1];
    end else if (op == c8alu_pkg::OP_BIT) begin
      z = ((a & m) == '0);
      n = m[W-1];
      v = m[W-2];
    end
  end

  assign rsp_o.result       = r;
  assign rsp_o.carry_out    = c;
  assign rsp_o.zero_out     = z;
  assign rsp_o.negative_out = n;
  assign rsp_o.overflow_out = v;

endmodule

### rtl/core/cpu8_alu_flags_unit.sv
`timescale 1ns / 1ps
// Datapath: an accepted request is held in the input register, then passes through
// the ALU logic into the result register, which drives the response.
// Throughput: one transaction per cycle while no response waits for rsp_o.ready;
// the result register then holds, and a full input register holds with it.
// Reset: rst_ni clears both valid bits; payload registers are not reset.

module cpu8_alu_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  c8alu_req_if.sink   req_i,
  c8alu_rsp_if.source rsp_o
);

  c8alu_pkg::req_t in_q;
  logic            in_valid_q;
  c8alu_pkg::rsp_t alu_rsp;
  c8alu_pkg::rsp_t out_q;
  logic            out_valid_q;
  logic            out_en;
  logic            in_en;

  assign out_en      = ~out_valid_q | rsp_o.ready;
  assign in_en       = ~in_valid_q | out_en;
  assign req_i.ready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid_q <= req_i.valid;
      end
      if (out_en) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && req_i.valid) begin
      in_q.req_type    <= req_i.req_type;
      in_q.acc_in      <= req_i.acc_in;
      in_q.operand     <= req_i.operand;
      in_q.carry_in    <= req_i.carry_in;
      in_q.overflow_in <= req_i.overflow_in;
    end
    if (out_en && in_valid_q) begin
      out_q <= alu_rsp;
    end
  end

  c8alu_core u_core (
    .req_i (in_q),
    .rsp_o (alu_rsp)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result       = out_q.result;
  assign rsp_o.carry_out    = out_q.carry_out;
  assign rsp_o.zero_out     = out_q.zero_out;
  assign rsp_o.negative_out = out_q.negative_out;
  assign rsp_o.overflow_out = out_q.overflow_out;

  // an empty result register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("request stalled with empty result register");

  // a held operation moves into the result register when it has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_en) |=> out_valid_q)
    else $error("operation lost between input and result register");

  // compare leaves the accumulator untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_en && (in_q.req_type == c8alu_pkg::OP_CMP))
      |=> (out_q.result == $past(in_q.acc_in)))
    else $error("compare modified the accumulator");

endmodule
